### src/bse_pkg.sv
// Shared types and constants for the bounded stack engine.
package bse_pkg;

   localparam int DEPTH_DEFAULT = 64;

   typedef logic [2:0]         func_type;
   typedef logic signed [31:0] word_type;
   typedef logic [6:0]         pos_type;
   typedef logic [2:0]         status_type;
   typedef logic [6:0]         count_type;

   localparam func_type FUNC_PUSH    = 3'd0;
   localparam func_type FUNC_POP     = 3'd1;
   localparam func_type FUNC_PEEK    = 3'd2;
   localparam func_type FUNC_MODIFY  = 3'd3;
   localparam func_type FUNC_DISPLAY = 3'd4;

   localparam status_type STATUS_OK        = 3'd0;
   localparam status_type STATUS_OVERFLOW  = 3'd1;
   localparam status_type STATUS_UNDERFLOW = 3'd2;
   localparam status_type STATUS_EMPTY     = 3'd3;
   localparam status_type STATUS_BADPOS    = 3'd4;

   typedef struct packed {
      logic capture;
      logic rd_top;
      logic rd_next;
      logic emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic func_valid;
      logic is_display;
      logic empty;
      logic at_bottom;
      logic out_free;
   } ctl_stat_type;

endpackage

### src/bse_channels.sv
// Valid/ready channel interfaces for request and response beats.
interface bse_req_if;
   logic                valid;
   logic                ready;
   bse_pkg::func_type   func;
   bse_pkg::word_type   value;
   bse_pkg::pos_type    position;

   modport source (output valid, func, value, position, input ready);
   modport sink   (input valid, func, value, position, output ready);
endinterface

interface bse_rsp_if;
   logic                 valid;
   logic                 ready;
   bse_pkg::status_type  status;
   bse_pkg::word_type    data;
   bse_pkg::count_type   count;
   logic                 last;

   modport source (output valid, status, data, count, last, input ready);
   modport sink   (input valid, status, data, count, last, output ready);
endinterface

### src/bse_datapath.sv
// Stack datapath: request latch, entry memory, fill count and response register.
module bse_datapath #(
   parameter int DEPTH = bse_pkg::DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bse_pkg::func_type     req_func,
   input  bse_pkg::word_type     req_value,
   input  bse_pkg::pos_type      req_position,
   input  bse_pkg::ctl_cmd_type  cmd,
   output bse_pkg::ctl_stat_type stat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bse_pkg::status_type   rsp_status,
   output bse_pkg::word_type     rsp_data,
   output bse_pkg::count_type    rsp_count,
   output logic                  rsp_last
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   bse_pkg::func_type   func_ff;
   bse_pkg::word_type   value_ff;
   bse_pkg::pos_type    pos_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       idx_ff, idx_in;
   bse_pkg::word_type   rd_data_ff;
   bse_pkg::word_type   mem [DEPTH];

   logic                rsp_valid_ff, rsp_valid_in;
   bse_pkg::status_type rsp_status_ff, rsp_status_in;
   bse_pkg::word_type   rsp_data_ff, rsp_data_in;
   bse_pkg::count_type  rsp_count_ff, rsp_count_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                empty, full, pos_ok, out_free;
   logic [CW-1:0]       count_m1;
   bse_pkg::pos_type    pos_m1;
   logic [AW-1:0]       top_idx, idx_m1;
   logic                wr_en, rd_en;
   logic [AW-1:0]       wr_addr, rd_addr;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CW'(DEPTH));
   assign count_m1 = count_ff - CW'(1);
   assign top_idx  = count_m1[AW-1:0];
   assign idx_m1   = idx_ff - AW'(1);
   assign pos_m1   = pos_ff - bse_pkg::pos_type'(1);
   assign pos_ok   = (pos_ff != '0) && (pos_ff <= bse_pkg::pos_type'(count_ff));
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign stat.func_valid = (func_ff == bse_pkg::FUNC_PUSH) || (func_ff == bse_pkg::FUNC_POP)
                         || (func_ff == bse_pkg::FUNC_PEEK) || (func_ff == bse_pkg::FUNC_MODIFY)
                         || (func_ff == bse_pkg::FUNC_DISPLAY);
   assign stat.is_display = (func_ff == bse_pkg::FUNC_DISPLAY);
   assign stat.empty      = empty;
   assign stat.at_bottom  = (idx_ff == '0);
   assign stat.out_free   = out_free;

   assign rd_en   = (cmd.rd_top && !empty) || cmd.rd_next;
   assign rd_addr = cmd.rd_next ? idx_m1 : top_idx;

   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.rd_top) begin
         idx_in = top_idx;
      end
      if (cmd.rd_next) begin
         idx_in = idx_m1;
      end
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = bse_pkg::STATUS_OK;
         rsp_data_in   = '0;
         rsp_last_in   = 1'b1;
         unique case (func_ff)
            bse_pkg::FUNC_PUSH: begin
               if (full) begin
                  rsp_status_in = bse_pkg::STATUS_OVERFLOW;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end
            end
            bse_pkg::FUNC_POP: begin
               if (empty) begin
                  rsp_status_in = bse_pkg::STATUS_UNDERFLOW;
               end else begin
                  rsp_data_in = rd_data_ff;
                  count_in    = count_m1;
               end
            end
            bse_pkg::FUNC_PEEK: begin
               if (empty) begin
                  rsp_status_in = bse_pkg::STATUS_EMPTY;
               end else begin
                  rsp_data_in = rd_data_ff;
               end
            end
            bse_pkg::FUNC_MODIFY: begin
               if (empty) begin
                  rsp_status_in = bse_pkg::STATUS_EMPTY;
               end else if (!pos_ok) begin
                  rsp_status_in = bse_pkg::STATUS_BADPOS;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = pos_m1[AW-1:0];
               end
            end
            bse_pkg::FUNC_DISPLAY: begin
               if (empty) begin
                  rsp_status_in = bse_pkg::STATUS_EMPTY;
               end else begin
                  rsp_data_in = rd_data_ff;
                  rsp_last_in = (idx_ff == '0);
               end
            end
            default: begin
               rsp_valid_in = rsp_valid_ff && !rsp_ready;
            end
         endcase
         rsp_count_in = bse_pkg::count_type'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
      if (wr_en) begin
         mem[wr_addr] <= value_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

### src/bse_controller.sv
// Operation sequencer: accept, memory read issue, response beats.
module bse_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bse_pkg::ctl_stat_type stat,
   output bse_pkg::ctl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.rd_top = stat.func_valid;
            state_in   = stat.func_valid ? ST_RESP : ST_IDLE;
         end
         ST_RESP: begin
            if (stat.out_free) begin
               cmd.emit    = 1'b1;
               cmd.rd_next = stat.is_display && !stat.empty && !stat.at_bottom;
               state_in    = cmd.rd_next ? ST_RESP : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/bounded_stack_engine.sv
// Top level of the bounded stack engine: sequencer plus stack datapath.
//
//   channel   dir  payload                       handshake
//   req_bus   in   func, value, position         valid/ready
//   rsp_bus   out  status, data, count, last     valid/ready
//
// Push, pop, peek and modify: each request steps through accept, memory read and response,
// and the entry memory has a registered read.
// Display: beats run top to bottom, one response beat per cycle while rsp_bus is ready.
// An empty display gives one EMPTY beat; unused func codes give no beat and return to idle.
// Reset clears the fill count and the sequencer; entries hold whatever was written.
// A stalled rsp_bus holds its beat; the next request is taken while it waits.
module bounded_stack_engine #(
   parameter int DEPTH = bse_pkg::DEPTH_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   bse_req_if.sink   req_bus,
   bse_rsp_if.source rsp_bus
);

   bse_pkg::ctl_cmd_type  cmd;
   bse_pkg::ctl_stat_type stat;

   bse_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bse_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_func     (req_bus.func),
      .req_value    (req_bus.value),
      .req_position (req_bus.position),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_valid    (rsp_bus.valid),
      .rsp_ready    (rsp_bus.ready),
      .rsp_status   (rsp_bus.status),
      .rsp_data     (rsp_bus.data),
      .rsp_count    (rsp_bus.count),
      .rsp_last     (rsp_bus.last)
   );

endmodule

### src/bse_checker.sv
// Port-level checks for the bounded stack engine, bound to the top level.
module bse_checker #(
   parameter int DEPTH = bse_pkg::DEPTH_DEFAULT
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input bse_pkg::status_type rsp_status,
   input bse_pkg::word_type   rsp_data,
   input bse_pkg::count_type  rsp_count,
   input logic                rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_data)
                                  && $stable(rsp_count) && $stable(rsp_last))
      else $error("response beat changed while stalled");

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != bse_pkg::STATUS_OK) |-> rsp_last && (rsp_data == '0))
      else $error("error beat not final or carries data");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == bse_pkg::STATUS_EMPTY)
                    || (rsp_status == bse_pkg::STATUS_UNDERFLOW)) |-> (rsp_count == '0))
      else $error("empty or underflow beat with nonzero count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count <= bse_pkg::count_type'(DEPTH)))
      else $error("count above depth");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind bounded_stack_engine bse_checker #(
   .DEPTH (DEPTH)
) u_bse_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_status (rsp_bus.status),
   .rsp_data   (rsp_bus.data),
   .rsp_count  (rsp_bus.count),
   .rsp_last   (rsp_bus.last)
);
